[sv/dpl_pkg.sv]
// Shared types and constants for the dual-prefix trie LPM block.
// No dependencies; used by every other file of the block except dpl_if.
package dpl_pkg;

  localparam int V4_KEY = 32;
  localparam int V6_KEY = 128;
  localparam logic [5:0] V4_MAXLEN = 6'd32;
  localparam logic [7:0] V6_MAXLEN = 8'd128;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_LOOK4  = 2'd2;
  localparam logic [1:0] ACT_LOOK6  = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CONFLICT = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BADARG   = 3'd4;

  typedef enum logic [1:0] {
    OP_CHECK,
    OP_PUT,
    OP_ERASE,
    OP_BEST
  } trie_op_t;

  typedef struct packed {
    logic     go;
    logic     load;
    trie_op_t op;
  } trie_cmd_t;

  typedef struct packed {
    logic busy;
    logic conflict;
    logic full;
    logic hit;
  } trie_sts_t;

endpackage

[sv/dpl_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing; used by the top level and by the environment.
interface dpl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] addr4;
  logic [5:0]  len4;
  logic [63:0] addr6_high;
  logic [63:0] addr6_low;
  logic [7:0]  len6;
  logic [31:0] handle;

  modport source (output valid, action, addr4, len4, addr6_high, addr6_low, len6, handle,
                  input ready);
  modport sink (input valid, action, addr4, len4, addr6_high, addr6_low, len6, handle,
                output ready);
endinterface

interface dpl_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        found;
  logic [31:0] match_handle;

  modport source (output valid, status, found, match_handle, input ready);
  modport sink (input valid, status, found, match_handle, output ready);
endinterface

[sv/dpl_trie.sv]
// Trie datapath: node memory, free stack, path memory and the walk sequencing.
// Depends on dpl_pkg; instantiated once per address family by the top level.
module dpl_trie #(
  parameter int POOL = 1024,
  parameter int KW   = 32,
  parameter int HB   = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dpl_pkg::trie_cmd_t          cmd,
  input  logic [KW-1:0]               key_in,
  input  logic [$clog2(KW+1)-1:0]     len_in,
  input  logic [HB-1:0]               h_in,
  output dpl_pkg::trie_sts_t          sts,
  output logic [HB-1:0]               hit_handle
);

  localparam int AW   = $clog2(POOL);
  localparam int NW   = 2*AW + 2 + HB;
  localparam int DW   = $clog2(KW+1);
  localparam int KIW  = $clog2(KW);
  localparam int PW   = AW + NW;
  localparam int CMPW = ((AW+2) > DW ? (AW+2) : DW) + 1;
  localparam int OK0  = HB;
  localparam int OK1  = HB + 1;
  localparam int K0   = HB + 2;
  localparam int K1   = HB + 2 + AW;

  typedef enum logic [2:0] {
    U_IDLE, U_START, U_WALK, U_TAKE, U_POP, U_LEAF, U_UP
  } ust_t;

  ust_t                st_r, st_nxt;
  dpl_pkg::trie_op_t   op_r, op_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [DW-1:0]       len_r, len_nxt;
  logic [HB-1:0]       h_r, h_nxt;
  logic [AW-1:0]       root_r, root_nxt;
  logic                root_ok_r, root_ok_nxt;
  logic [AW:0]         fresh_r, fresh_nxt;
  logic [AW:0]         top_r, top_nxt;
  logic [AW-1:0]       n_r, n_nxt;
  logic [DW-1:0]       d_r, d_nxt;
  logic [NW-1:0]       cur_r, cur_nxt;
  logic                rootpend_r, rootpend_nxt;
  logic                conflict_r, conflict_nxt;
  logic                full_r, full_nxt;
  logic                hit_r, hit_nxt;
  logic [HB-1:0]       best_r, best_nxt;

  logic [NW-1:0] nmem [POOL];
  logic [AW-1:0] smem [POOL];
  logic [PW-1:0] pmem [KW+1];
  logic [NW-1:0] mem_q;
  logic [AW-1:0] stk_q;
  logic [PW-1:0] path_q;

  logic          nwe, swe, pwe;
  logic [AW-1:0] nwa, nra, swa, sra, swd;
  logic [NW-1:0] nwd;
  logic [DW-1:0] pwa, pra;
  logic [PW-1:0] pwd;

  logic [KIW-1:0] bi;
  logic           b, okb, at_end;
  logic [AW-1:0]  kidb, lc, pidx, gidx;
  logic           gen;
  logic [NW-1:0]  m;
  logic [CMPW-1:0] avail;

  always_ff @(posedge clk) begin
    if (nwe) nmem[nwa] <= nwd;
    mem_q <= nmem[nra];
    if (swe) smem[swa] <= swd;
    stk_q <= smem[sra];
    if (pwe) pmem[pwa] <= pwd;
    path_q <= pmem[pra];
  end

  assign bi = KIW'(KW-1) - d_r[KIW-1:0];
  assign b  = key_r[bi];
  assign okb  = b ? mem_q[OK1] : mem_q[OK0];
  assign kidb = b ? mem_q[K1 +: AW] : mem_q[K0 +: AW];
  assign avail = CMPW'(POOL) - CMPW'(fresh_r) + CMPW'(top_r);
  assign at_end = (op_r == dpl_pkg::OP_BEST) ? (d_r == DW'(KW)) : (d_r == len_r);
  assign pidx = path_q[PW-1:NW];
  assign lc = (st_r == U_POP) ? stk_q : fresh_r[AW-1:0];

  always_comb begin
    st_nxt = st_r; op_nxt = op_r; key_nxt = key_r; len_nxt = len_r; h_nxt = h_r;
    root_nxt = root_r; root_ok_nxt = root_ok_r; fresh_nxt = fresh_r; top_nxt = top_r;
    n_nxt = n_r; d_nxt = d_r; cur_nxt = cur_r; rootpend_nxt = rootpend_r;
    conflict_nxt = conflict_r; full_nxt = full_r; hit_nxt = hit_r; best_nxt = best_r;
    nwe = 1'b0; nwa = n_r; nwd = cur_r; nra = n_r;
    pwe = 1'b0; pwa = d_r; pwd = {n_r, mem_q}; pra = d_r;
    swe = 1'b0; swa = top_r[AW-1:0]; swd = n_r; sra = top_r[AW-1:0] - AW'(1);
    gen = 1'b0; gidx = n_r; m = mem_q;
    case (st_r)
      U_IDLE: begin
        if (cmd.go) begin
          if (cmd.load) begin
            key_nxt = key_in; len_nxt = len_in; h_nxt = h_in;
          end
          op_nxt = cmd.op;
          conflict_nxt = 1'b0; full_nxt = 1'b0; hit_nxt = 1'b0; best_nxt = '0;
          st_nxt = U_START;
        end
      end
      U_START: begin
        nra = root_r; n_nxt = root_r; d_nxt = '0;
        if (!root_ok_r) begin
          case (op_r)
            dpl_pkg::OP_CHECK: begin
              full_nxt = (CMPW'(len_r) + CMPW'(1)) > avail;
              st_nxt = U_IDLE;
            end
            dpl_pkg::OP_PUT: begin
              rootpend_nxt = 1'b1;
              st_nxt = U_TAKE;
            end
            default: st_nxt = U_IDLE;
          endcase
        end else begin
          st_nxt = U_WALK;
        end
      end
      U_WALK: begin
        pwe = 1'b1;
        case (op_r)
          dpl_pkg::OP_CHECK: begin
            if (at_end) begin
              conflict_nxt = mem_q[HB-1:0] != '0;
              st_nxt = U_IDLE;
            end else if (!okb) begin
              full_nxt = CMPW'(len_r - d_r) > avail;
              st_nxt = U_IDLE;
            end
          end
          dpl_pkg::OP_BEST: begin
            if (mem_q[HB-1:0] != '0) best_nxt = mem_q[HB-1:0];
            if (at_end || !okb) st_nxt = U_IDLE;
          end
          dpl_pkg::OP_ERASE: begin
            if (at_end) begin
              hit_nxt = 1'b1;
              m[HB-1:0] = '0;
              nwe = 1'b1; nwa = n_r; nwd = m;
              if (!mem_q[OK0] && !mem_q[OK1]) begin
                gen = 1'b1; gidx = n_r;
                if (d_r == '0) begin
                  root_ok_nxt = 1'b0;
                  st_nxt = U_IDLE;
                end else begin
                  pra = d_r - DW'(1);
                  d_nxt = d_r - DW'(1);
                  st_nxt = U_UP;
                end
              end else begin
                st_nxt = U_IDLE;
              end
            end else if (!okb) begin
              st_nxt = U_IDLE;
            end
          end
          default: begin
            if (at_end) begin
              cur_nxt = mem_q;
              st_nxt = U_LEAF;
            end else if (!okb) begin
              cur_nxt = mem_q;
              st_nxt = U_TAKE;
            end
          end
        endcase
        if (!at_end && okb && st_nxt == U_WALK) begin
          nra = kidb; n_nxt = kidb; d_nxt = d_r + DW'(1);
        end
      end
      U_TAKE, U_POP: begin
        if (st_r == U_TAKE && top_r != '0) begin
          top_nxt = top_r - (AW+1)'(1);
          st_nxt = U_POP;
        end else begin
          if (st_r == U_TAKE) fresh_nxt = fresh_r + (AW+1)'(1);
          n_nxt = lc;
          cur_nxt = '0;
          if (rootpend_r) begin
            root_nxt = lc; root_ok_nxt = 1'b1; rootpend_nxt = 1'b0;
            st_nxt = (len_r == '0) ? U_LEAF : U_TAKE;
          end else begin
            m = cur_r;
            if (b) begin
              m[K1 +: AW] = lc; m[OK1] = 1'b1;
            end else begin
              m[K0 +: AW] = lc; m[OK0] = 1'b1;
            end
            nwe = 1'b1; nwa = n_r; nwd = m;
            d_nxt = d_r + DW'(1);
            st_nxt = ((d_r + DW'(1)) == len_r) ? U_LEAF : U_TAKE;
          end
        end
      end
      U_LEAF: begin
        m = cur_r;
        m[HB-1:0] = h_r;
        nwe = 1'b1; nwa = n_r; nwd = m;
        st_nxt = U_IDLE;
      end
      U_UP: begin
        m = path_q[NW-1:0];
        if (b) m[OK1] = 1'b0;
        else m[OK0] = 1'b0;
        nwe = 1'b1; nwa = pidx; nwd = m;
        if (m[HB-1:0] == '0 && !m[OK0] && !m[OK1]) begin
          gen = 1'b1; gidx = pidx;
          if (d_r == '0) begin
            root_ok_nxt = 1'b0;
            st_nxt = U_IDLE;
          end else begin
            pra = d_r - DW'(1);
            d_nxt = d_r - DW'(1);
          end
        end else begin
          st_nxt = U_IDLE;
        end
      end
      default: st_nxt = U_IDLE;
    endcase
    if (gen && top_r < (AW+1)'(POOL)) begin
      swe = 1'b1; swa = top_r[AW-1:0]; swd = gidx;
      top_nxt = top_r + (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= U_IDLE;
      root_ok_r  <= 1'b0;
      fresh_r    <= '0;
      top_r      <= '0;
      rootpend_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      root_ok_r  <= root_ok_nxt;
      fresh_r    <= fresh_nxt;
      top_r      <= top_nxt;
      rootpend_r <= rootpend_nxt;
    end
    op_r <= op_nxt; key_r <= key_nxt; len_r <= len_nxt; h_r <= h_nxt;
    root_r <= root_nxt; n_r <= n_nxt; d_r <= d_nxt; cur_r <= cur_nxt;
    conflict_r <= conflict_nxt; full_r <= full_nxt; hit_r <= hit_nxt; best_r <= best_nxt;
  end

  assign sts.busy     = st_r != U_IDLE;
  assign sts.conflict = conflict_r;
  assign sts.full     = full_r;
  assign sts.hit      = hit_r;
  assign hit_handle   = best_r;

endmodule

[sv/dpl_ctrl.sv]
// Request controller: decodes actions, sequences the two trie units, holds the response.
// Depends on dpl_pkg; instantiated by the top level.
module dpl_ctrl #(
  parameter int HB = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [5:0]         len4,
  input  logic [7:0]         len6,
  input  logic               hzero,
  output dpl_pkg::trie_cmd_t cmd4,
  output dpl_pkg::trie_cmd_t cmd6,
  input  dpl_pkg::trie_sts_t sts4,
  input  dpl_pkg::trie_sts_t sts6,
  input  logic [HB-1:0]      hh4,
  input  logic [HB-1:0]      hh6,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic               found,
  output logic [31:0]        match
);

  typedef enum logic [2:0] {
    C_IDLE, C_CHK, C_PUT, C_ERASE, C_LOOK, C_FIN
  } cst_t;

  cst_t        st_r, st_nxt;
  logic        lk6_r, lk6_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  status_r, status_nxt, fs_r, fs_nxt;
  logic        found_r, found_nxt, ff_r, ff_nxt;
  logic [31:0] match_r, match_nxt, fm_r, fm_nxt;

  logic           acc, badlen, idle2;
  logic [HB-1:0]  hsel;
  logic [HB+31:0] hx;

  assign in_ready = st_r == C_IDLE;
  assign acc      = in_valid && in_ready;
  assign badlen   = (len4 > dpl_pkg::V4_MAXLEN) || (len6 > dpl_pkg::V6_MAXLEN);
  assign idle2    = !sts4.busy && !sts6.busy;
  assign hsel     = lk6_r ? hh6 : hh4;
  assign hx       = {32'd0, hsel};

  always_comb begin
    st_nxt = st_r; lk6_nxt = lk6_r;
    fs_nxt = fs_r; ff_nxt = ff_r; fm_nxt = fm_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt = status_r; found_nxt = found_r; match_nxt = match_r;
    cmd4 = '{go: 1'b0, load: 1'b0, op: dpl_pkg::OP_CHECK};
    cmd6 = '{go: 1'b0, load: 1'b0, op: dpl_pkg::OP_CHECK};
    case (st_r)
      C_IDLE: begin
        if (acc) begin
          ff_nxt = 1'b0; fm_nxt = '0;
          case (action)
            dpl_pkg::ACT_INSERT: begin
              if (badlen || hzero) begin
                fs_nxt = dpl_pkg::ST_BADARG; st_nxt = C_FIN;
              end else begin
                cmd4 = '{go: 1'b1, load: 1'b1, op: dpl_pkg::OP_CHECK};
                cmd6 = '{go: 1'b1, load: 1'b1, op: dpl_pkg::OP_CHECK};
                st_nxt = C_CHK;
              end
            end
            dpl_pkg::ACT_REMOVE: begin
              if (badlen) begin
                fs_nxt = dpl_pkg::ST_BADARG; st_nxt = C_FIN;
              end else begin
                cmd4 = '{go: 1'b1, load: 1'b1, op: dpl_pkg::OP_ERASE};
                cmd6 = '{go: 1'b1, load: 1'b1, op: dpl_pkg::OP_ERASE};
                st_nxt = C_ERASE;
              end
            end
            dpl_pkg::ACT_LOOK4: begin
              cmd4 = '{go: 1'b1, load: 1'b1, op: dpl_pkg::OP_BEST};
              lk6_nxt = 1'b0; st_nxt = C_LOOK;
            end
            default: begin
              cmd6 = '{go: 1'b1, load: 1'b1, op: dpl_pkg::OP_BEST};
              lk6_nxt = 1'b1; st_nxt = C_LOOK;
            end
          endcase
        end
      end
      C_CHK: begin
        if (idle2) begin
          st_nxt = C_FIN;
          if (sts4.conflict) fs_nxt = dpl_pkg::ST_CONFLICT;
          else if (sts4.full) fs_nxt = dpl_pkg::ST_FULL;
          else if (sts6.conflict) fs_nxt = dpl_pkg::ST_CONFLICT;
          else if (sts6.full) fs_nxt = dpl_pkg::ST_FULL;
          else begin
            cmd4 = '{go: 1'b1, load: 1'b0, op: dpl_pkg::OP_PUT};
            cmd6 = '{go: 1'b1, load: 1'b0, op: dpl_pkg::OP_PUT};
            st_nxt = C_PUT;
          end
        end
      end
      C_PUT: begin
        if (idle2) begin
          fs_nxt = dpl_pkg::ST_OK; st_nxt = C_FIN;
        end
      end
      C_ERASE: begin
        if (idle2) begin
          ff_nxt = sts4.hit || sts6.hit;
          fs_nxt = (sts4.hit || sts6.hit) ? dpl_pkg::ST_OK : dpl_pkg::ST_NOTFOUND;
          st_nxt = C_FIN;
        end
      end
      C_LOOK: begin
        if (idle2) begin
          ff_nxt = hsel != '0;
          fm_nxt = hx[31:0];
          fs_nxt = (hsel != '0) ? dpl_pkg::ST_OK : dpl_pkg::ST_NOTFOUND;
          st_nxt = C_FIN;
        end
      end
      C_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          status_nxt = fs_r; found_nxt = ff_r; match_nxt = fm_r;
          st_nxt = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= C_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lk6_r <= lk6_nxt; fs_r <= fs_nxt; ff_r <= ff_nxt; fm_r <= fm_nxt;
    status_r <= status_nxt; found_r <= found_nxt; match_r <= match_nxt;
  end

  assign out_valid = out_valid_r;
  assign status    = status_r;
  assign found     = found_r;
  assign match     = match_r;

endmodule

[sv/dual_prefix_trie_lpm_top.sv]
// Flow: a lookup walks one trie; a remove walks both tries and frees emptied nodes upward;
// an insert runs a check walk in both tries, then a put walk with node allocation.
// Throughput: one request at a time.
// Reset: synchronous, both tries empty and free lists cleared; no memory clearing pass.
// Depends on dpl_pkg, dpl_if, dpl_trie and dpl_ctrl.
module dual_prefix_trie_lpm_top #(
  parameter int V4_POOL     = 1024,
  parameter int V6_POOL     = 4096,
  parameter int HANDLE_BITS = 32
) (
  input logic      clk,
  input logic      rst_n,
  dpl_req_if.sink  in_req,
  dpl_rsp_if.source out_rsp
);

  dpl_pkg::trie_cmd_t cmd4, cmd6;
  dpl_pkg::trie_sts_t sts4, sts6;
  logic [HANDLE_BITS-1:0] hh4, hh6, hin;

  assign hin = HANDLE_BITS'(in_req.handle);

  dpl_ctrl #(.HB(HANDLE_BITS)) u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_req.valid), .in_ready(in_req.ready),
    .action(in_req.action), .len4(in_req.len4), .len6(in_req.len6),
    .hzero(hin == '0),
    .cmd4(cmd4), .cmd6(cmd6), .sts4(sts4), .sts6(sts6), .hh4(hh4), .hh6(hh6),
    .out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
    .status(out_rsp.status), .found(out_rsp.found), .match(out_rsp.match_handle)
  );

  dpl_trie #(.POOL(V4_POOL), .KW(dpl_pkg::V4_KEY), .HB(HANDLE_BITS)) u_v4 (
    .clk(clk), .rst_n(rst_n), .cmd(cmd4),
    .key_in(in_req.addr4), .len_in(in_req.len4), .h_in(hin),
    .sts(sts4), .hit_handle(hh4)
  );

  dpl_trie #(.POOL(V6_POOL), .KW(dpl_pkg::V6_KEY), .HB(HANDLE_BITS)) u_v6 (
    .clk(clk), .rst_n(rst_n), .cmd(cmd6),
    .key_in({in_req.addr6_high, in_req.addr6_low}), .len_in(in_req.len6), .h_in(hin),
    .sts(sts6), .hit_handle(hh6)
  );

endmodule

[sv/dpl_checker.sv]
// Port-level checks for the dual-prefix trie LPM top level, bound to it below.
// Depends on dpl_pkg and dual_prefix_trie_lpm_top.
module dpl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic        found,
  input logic [31:0] match
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a previous one is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found) && $stable(match))
    else $error("stalled response changed");

  a_notfound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == dpl_pkg::ST_NOTFOUND |-> !found && match == '0)
    else $error("not-found response carries a hit");

  a_match_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && match != '0 |-> found && status == dpl_pkg::ST_OK)
    else $error("match handle without ok status");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("response valid after reset");

endmodule

bind dual_prefix_trie_lpm_top dpl_checker u_dpl_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
  .status(out_rsp.status), .found(out_rsp.found), .match(out_rsp.match_handle)
);

[bench/tb_top.sv]
// Testbench for dual_prefix_trie_lpm_top: directed table then random insert/remove/lookup.
// Results are checked against an in-bench trie predictor; depends on dpl_pkg and dpl_if.
`timescale 1ns / 1ps
module tb_top;

  typedef struct {
    logic [1:0]   action;
    logic [31:0]  addr4;
    logic [5:0]   len4;
    logic [127:0] addr6;
    logic [7:0]   len6;
    logic [31:0]  handle;
  } req_t;

  typedef struct {
    logic [2:0]  status;
    logic        found;
    logic [31:0] match_handle;
  } rsp_t;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t e;
  } row_t;

  typedef struct {
    int       kid[2];
    bit       kid_ok[2];
    bit [31:0] h;
  } node_t;

  typedef struct {
    node_t mem[];
    int    stk[];
    int    pool;
    int    root;
    bit    root_ok;
    int    fresh;
    int    top;
  } trie_t;

  logic clk;
  logic rst_n;
  dpl_req_if in_req();
  dpl_rsp_if out_rsp();

  dual_prefix_trie_lpm_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req.sink), .out_rsp(out_rsp.source)
  );

  trie_t t4, t6;
  rsp_t exp_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit in_done = 0;
  req_t pfx4_q[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic bit kbit(logic [127:0] k, int lvl);
    return k[127 - lvl];
  endfunction

  function automatic void trie_init(ref trie_t t, input int pool);
    t.mem = new[pool];
    t.stk = new[pool];
    t.pool = pool;
    t.root_ok = 0;
    t.root = 0;
    t.fresh = 0;
    t.top = 0;
  endfunction

  function automatic int walk_missing(ref trie_t t, input logic [127:0] k, input int len);
    int n;
    if (!t.root_ok) return len + 1;
    n = t.root;
    for (int d = 0; d < len; d++) begin
      if (!t.mem[n].kid_ok[kbit(k, d)]) return len - d;
      n = t.mem[n].kid[kbit(k, d)];
    end
    return 0;
  endfunction

  function automatic bit [31:0] held_at(ref trie_t t, input logic [127:0] k, input int len);
    int n;
    if (!t.root_ok) return 0;
    n = t.root;
    for (int d = 0; d < len; d++) begin
      if (!t.mem[n].kid_ok[kbit(k, d)]) return 0;
      n = t.mem[n].kid[kbit(k, d)];
    end
    return t.mem[n].h;
  endfunction

  function automatic int node_take(ref trie_t t);
    int n;
    if (t.top > 0) begin
      t.top--;
      n = t.stk[t.top];
    end else begin
      n = t.fresh % t.pool;
      t.fresh++;
    end
    t.mem[n].kid_ok[0] = 0;
    t.mem[n].kid_ok[1] = 0;
    t.mem[n].kid[0] = 0;
    t.mem[n].kid[1] = 0;
    t.mem[n].h = 0;
    return n;
  endfunction

  function automatic void prefix_put(ref trie_t t, input logic [127:0] k, input int len,
                                     input bit [31:0] h);
    int n, c;
    bit b;
    if (!t.root_ok) begin
      t.root = node_take(t);
      t.root_ok = 1;
    end
    n = t.root;
    for (int d = 0; d < len; d++) begin
      b = kbit(k, d);
      if (!t.mem[n].kid_ok[b]) begin
        c = node_take(t);
        t.mem[n].kid[b] = c;
        t.mem[n].kid_ok[b] = 1;
      end
      n = t.mem[n].kid[b];
    end
    t.mem[n].h = h;
  endfunction

  function automatic bit prefix_erase(ref trie_t t, input logic [127:0] k, input int len);
    int path[129];
    int n;
    if (!t.root_ok) return 0;
    path[0] = t.root;
    for (int d = 0; d < len; d++) begin
      if (!t.mem[path[d]].kid_ok[kbit(k, d)]) return 0;
      path[d + 1] = t.mem[path[d]].kid[kbit(k, d)];
    end
    t.mem[path[len]].h = 0;
    for (int j = len; j >= 0; j--) begin
      n = path[j];
      if (t.mem[n].h != 0 || t.mem[n].kid_ok[0] || t.mem[n].kid_ok[1]) break;
      if (t.top < t.pool) begin
        t.stk[t.top] = n;
        t.top++;
      end
      if (j == 0) t.root_ok = 0;
      else t.mem[path[j - 1]].kid_ok[kbit(k, j - 1)] = 0;
    end
    return 1;
  endfunction

  function automatic bit [31:0] longest_match(ref trie_t t, input logic [127:0] k,
                                              input int depth);
    bit [31:0] last;
    int n;
    last = 0;
    if (!t.root_ok) return 0;
    n = t.root;
    for (int d = 0; d <= depth; d++) begin
      if (t.mem[n].h != 0) last = t.mem[n].h;
      if (d >= depth) break;
      if (!t.mem[n].kid_ok[kbit(k, d)]) break;
      n = t.mem[n].kid[kbit(k, d)];
    end
    return last;
  endfunction

  function automatic rsp_t lpm_predict(req_t r);
    rsp_t o;
    logic [127:0] k4;
    bit r4, r6;
    k4 = {r.addr4, 96'd0};
    o.status = dpl_pkg::ST_OK;
    o.found = 0;
    o.match_handle = 0;
    case (r.action)
      dpl_pkg::ACT_INSERT: begin
        if (r.handle == 0 || r.len4 > dpl_pkg::V4_MAXLEN || r.len6 > dpl_pkg::V6_MAXLEN)
          o.status = dpl_pkg::ST_BADARG;
        else if (held_at(t4, k4, r.len4) != 0) o.status = dpl_pkg::ST_CONFLICT;
        else if (walk_missing(t4, k4, r.len4) > t4.pool - t4.fresh + t4.top)
          o.status = dpl_pkg::ST_FULL;
        else if (held_at(t6, r.addr6, r.len6) != 0) o.status = dpl_pkg::ST_CONFLICT;
        else if (walk_missing(t6, r.addr6, r.len6) > t6.pool - t6.fresh + t6.top)
          o.status = dpl_pkg::ST_FULL;
        else begin
          prefix_put(t4, k4, r.len4, r.handle);
          prefix_put(t6, r.addr6, r.len6, r.handle);
        end
      end
      dpl_pkg::ACT_REMOVE: begin
        if (r.len4 > dpl_pkg::V4_MAXLEN || r.len6 > dpl_pkg::V6_MAXLEN)
          o.status = dpl_pkg::ST_BADARG;
        else begin
          r4 = prefix_erase(t4, k4, r.len4);
          r6 = prefix_erase(t6, r.addr6, r.len6);
          o.found = r4 | r6;
          o.status = o.found ? dpl_pkg::ST_OK : dpl_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        if (r.action == dpl_pkg::ACT_LOOK4)
          o.match_handle = longest_match(t4, k4, dpl_pkg::V4_KEY);
        else o.match_handle = longest_match(t6, r.addr6, dpl_pkg::V6_KEY);
        o.found = o.match_handle != 0;
        o.status = o.found ? dpl_pkg::ST_OK : dpl_pkg::ST_NOTFOUND;
      end
    endcase
    return o;
  endfunction

  function automatic req_t mk(logic [1:0] a, logic [31:0] a4, logic [5:0] l4,
                              logic [127:0] a6, logic [7:0] l6, logic [31:0] h);
    req_t r;
    r.action = a;
    r.addr4 = a4;
    r.len4 = l4;
    r.addr6 = a6;
    r.len6 = l6;
    r.handle = h;
    return r;
  endfunction

  function automatic logic [127:0] rnd128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // random request: any action, mostly on a recycled prefix set so tries grow deep
  function automatic req_t rand_req();
    req_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r = mk(2'($urandom_range(0, 3)), $urandom, 6'($urandom_range(0, 32)), rnd128(),
           8'($urandom_range(0, 128)), $urandom);
    if ($urandom_range(0, 3) == 0) begin
      r.len4 = 6'($urandom_range(24, 32));
      r.len6 = 8'($urandom_range(100, 128));
    end
    if (pfx4_q.size() > 0 && sel < 60) begin
      req_t p;
      p = pfx4_q[$urandom_range(0, pfx4_q.size() - 1)];
      r.addr4 = p.addr4;
      r.addr6 = p.addr6;
      if (sel < 30) begin
        r.len4 = p.len4;
        r.len6 = p.len6;
      end else begin
        r.addr4 = p.addr4 ^ 32'($urandom_range(0, 3) << $urandom_range(0, 31));
      end
    end
    if (sel >= 95) begin
      r.len4 = 6'($urandom_range(0, 63));
      r.len6 = 8'($urandom_range(0, 255));
    end
    if (sel >= 97) r.handle = 0;
    if (r.action == dpl_pkg::ACT_INSERT) pfx4_q.push_back(r);
    if (pfx4_q.size() > 40) void'(pfx4_q.pop_front());
    return r;
  endfunction

  task automatic send_req(req_t r);
    int gap;
    gap = $urandom_range(0, 1) ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_req.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_req.valid <= 1;
    in_req.action <= r.action;
    in_req.addr4 <= r.addr4;
    in_req.len4 <= r.len4;
    in_req.addr6_high <= r.addr6[127:64];
    in_req.addr6_low <= r.addr6[63:0];
    in_req.len6 <= r.len6;
    in_req.handle <= r.handle;
    do @(posedge clk); while (!in_req.ready);
    @(negedge clk);
  endtask

  row_t rows[$];

  initial begin
    rsp_t p;
    trie_init(t4, 1024);
    trie_init(t6, 4096);
    rst_n = 0;
    in_req.valid = 0;
    in_req.action = dpl_pkg::ACT_LOOK4;
    in_req.addr4 = 0;
    in_req.len4 = 0;
    in_req.addr6_high = 0;
    in_req.addr6_low = 0;
    in_req.len6 = 0;
    in_req.handle = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    rows.push_back('{mk(dpl_pkg::ACT_LOOK4, 32'h0, 0, 0, 0, 0), 1,
                     '{dpl_pkg::ST_NOTFOUND, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_LOOK6, 32'hffffffff, 0, '1, 0, 0), 1,
                     '{dpl_pkg::ST_NOTFOUND, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_REMOVE, 0, 0, 0, 0, 0), 1,
                     '{dpl_pkg::ST_NOTFOUND, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_INSERT, 0, 0, 0, 0, 0), 1,
                     '{dpl_pkg::ST_BADARG, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_INSERT, 0, 33, 0, 0, 5), 1,
                     '{dpl_pkg::ST_BADARG, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_INSERT, 0, 0, 0, 129, 5), 1,
                     '{dpl_pkg::ST_BADARG, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_REMOVE, 0, 63, 0, 255, 5), 1,
                     '{dpl_pkg::ST_BADARG, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_INSERT, 0, 0, 0, 0, 32'hffffffff), 0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_INSERT, 32'hffffffff, 32, '1, 128, 32'h1), 0,
                     '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_INSERT, 32'h0, 0, 1, 128, 7), 0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_INSERT, 32'h1, 32, 0, 0, 7), 0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_INSERT, 32'hc0a80000, 16, {64'h20010db8, 64'h0}, 32, 9),
                     0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_LOOK4, 32'hc0a80101, 0, 0, 0, 0), 0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_LOOK4, 32'hffffffff, 0, 0, 0, 0), 0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_LOOK6, 0, 0, {64'h0000000020010db8, 64'h5}, 0, 0),
                     0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_LOOK6, 0, 0, '1, 0, 0), 0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_REMOVE, 32'hffffffff, 32, '1, 128, 0), 0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_REMOVE, 32'hffffffff, 32, '1, 128, 0), 0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_LOOK4, 32'hffffffff, 0, 0, 0, 0), 0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_REMOVE, 0, 0, 0, 0, 0), 0, '{0, 0, 0}});
    rows.push_back('{mk(dpl_pkg::ACT_LOOK6, 0, 0, 0, 0, 0), 0, '{0, 0, 0}});
    foreach (rows[i]) begin
      p = lpm_predict(rows[i].r);
      if (rows[i].typed && (p.status !== rows[i].e.status || p.found !== rows[i].e.found ||
                            p.match_handle !== rows[i].e.match_handle)) begin
        $display("%0t table row %0d: expected %0d/%0d/%0h predicted %0d/%0d/%0h", $time, i,
                 rows[i].e.status, rows[i].e.found, rows[i].e.match_handle,
                 p.status, p.found, p.match_handle);
        errors++;
      end
      exp_q.push_back(rows[i].typed ? rows[i].e : p);
      send_req(rows[i].r);
    end
    for (int i = 0; i < 850; i++) begin
      req_t r;
      r = rand_req();
      exp_q.push_back(lpm_predict(r));
      send_req(r);
    end
    in_req.valid <= 0;
    in_done = 1;
  end

  initial begin
    int gap;
    out_rsp.ready = 0;
    @(negedge clk);
    forever begin
      gap = $urandom_range(0, 1) ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        out_rsp.ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_rsp.ready <= 1;
      do @(posedge clk); while (!out_rsp.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (exp_q.size() == 0) begin
        $display("%0t unexpected response %0d/%0d/%0h", $time, out_rsp.status,
                 out_rsp.found, out_rsp.match_handle);
        errors++;
      end else begin
        rsp_t e;
        e = exp_q.pop_front();
        if (e.status !== out_rsp.status || e.found !== out_rsp.found ||
            e.match_handle !== out_rsp.match_handle) begin
          $display("%0t mismatch: expected %0d/%0d/%0h actual %0d/%0d/%0h", $time,
                   e.status, e.found, e.match_handle, out_rsp.status, out_rsp.found,
                   out_rsp.match_handle);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (in_done && exp_q.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0 && exp_q.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    wait (idle_cycles >= 5000);
    $display("Regression FAIL");
    $finish;
  end
endmodule
